### rtl/dllm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linked list manager.
// No dependencies; used by dllm_ctrl, dllm_dp and the top level.
package dllm_pkg;

   localparam int NODES  = 64;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int OP_W   = 3;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_POP_FRONT = 3'd2,
      OP_POP_BACK  = 3'd3,
      OP_UNLINK    = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // issue: word taken, link reads and first insert writes
   // commit: second link writes, head/tail/count update, response load
   typedef struct packed {
      logic issue;
      logic commit;
   } cmd_type;

   function automatic logic is_null(input logic [LINK_W-1:0] link);
      return link >= NULL_LINK;
   endfunction

endpackage

### rtl/dllm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the linked list manager: idle / execute.
// Depends on dllm_pkg.
module dllm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output dllm_pkg::cmd_type cmd
);
   import dllm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.issue  = 1'b0;
      cmd.commit = 1'b0;
      busy       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.issue = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/dllm_dp.sv
`timescale 1ns / 1ps
// Datapath: next/prev link memories, head, tail, count and response registers.
// Depends on dllm_pkg; driven by dllm_ctrl commands.
module dllm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  dllm_pkg::cmd_type             cmd,
   input  logic [dllm_pkg::OP_W-1:0]     req_op,
   input  logic [dllm_pkg::NODE_W-1:0]   req_node,
   output logic [dllm_pkg::NODE_W-1:0]   rsp_node_out,
   output logic                          rsp_status,
   output logic [dllm_pkg::CNT_W-1:0]    rsp_list_count
);
   import dllm_pkg::*;

   logic [LINK_W-1:0] next_mem [NODES];
   logic [LINK_W-1:0] prev_mem [NODES];

   logic [OP_W-1:0]   op_ff;
   logic [NODE_W-1:0] node_ff;
   logic [LINK_W-1:0] rd_next_ff, rd_prev_ff;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic [NODE_W-1:0] rd_addr;
   logic              next_we, prev_we;
   logic [NODE_W-1:0] next_waddr, prev_waddr;
   logic [LINK_W-1:0] next_wdata, prev_wdata;
   logic [LINK_W-1:0] node_link;
   logic              empty;
   logic [LINK_W-1:0] pop_next, pop_prev;

   assign node_link = {1'b0, node_ff};
   assign empty     = (count_ff == '0);
   // link read through a null head or tail reads as null
   assign pop_next  = is_null(head_ff) ? NULL_LINK : rd_next_ff;
   assign pop_prev  = is_null(tail_ff) ? NULL_LINK : rd_prev_ff;

   // read address picked from the incoming word
   always_comb begin
      unique case (op_type'(req_op))
         OP_POP_FRONT: rd_addr = head_ff[NODE_W-1:0];
         OP_POP_BACK:  rd_addr = tail_ff[NODE_W-1:0];
         default:      rd_addr = req_node;
      endcase
   end

   // write ports: insert writes the new node at issue, neighbor fixups at commit
   always_comb begin
      next_we    = 1'b0;
      next_waddr = req_node;
      next_wdata = NULL_LINK;
      prev_we    = 1'b0;
      prev_waddr = req_node;
      prev_wdata = NULL_LINK;
      if (cmd.issue) begin
         case (op_type'(req_op))
            OP_INS_FRONT: begin
               next_we    = 1'b1;
               next_wdata = head_ff;
               prev_we    = 1'b1;
               prev_wdata = NULL_LINK;
            end
            OP_INS_BACK: begin
               next_we    = 1'b1;
               next_wdata = NULL_LINK;
               prev_we    = 1'b1;
               prev_wdata = tail_ff;
            end
            default: ;
         endcase
      end else if (cmd.commit && !empty) begin
         case (op_type'(op_ff))
            OP_INS_FRONT: begin
               prev_we    = !is_null(head_ff);
               prev_waddr = head_ff[NODE_W-1:0];
               prev_wdata = node_link;
            end
            OP_INS_BACK: begin
               next_we    = !is_null(tail_ff);
               next_waddr = tail_ff[NODE_W-1:0];
               next_wdata = node_link;
            end
            OP_POP_FRONT: begin
               prev_we    = !is_null(pop_next);
               prev_waddr = pop_next[NODE_W-1:0];
               prev_wdata = NULL_LINK;
            end
            OP_POP_BACK: begin
               next_we    = !is_null(pop_prev);
               next_waddr = pop_prev[NODE_W-1:0];
               next_wdata = NULL_LINK;
            end
            OP_UNLINK: begin
               next_we    = !is_null(rd_prev_ff);
               next_waddr = rd_prev_ff[NODE_W-1:0];
               next_wdata = rd_next_ff;
               prev_we    = !is_null(rd_next_ff);
               prev_waddr = rd_next_ff[NODE_W-1:0];
               prev_wdata = rd_prev_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         op_ff      <= req_op;
         node_ff    <= req_node;
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   // list registers and response for the word in flight
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rsp_node_in   = '0;
      rsp_status_in = 1'b0;
      case (op_type'(op_ff))
         OP_INS_FRONT: begin
            rsp_node_in = node_ff;
            if (empty) begin
               tail_in = node_link;
            end
            head_in = node_link;
            if (count_ff != CNT_W'(NODES)) begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_INS_BACK: begin
            rsp_node_in = node_ff;
            if (empty) begin
               head_in = node_link;
            end
            tail_in = node_link;
            if (count_ff != CNT_W'(NODES)) begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               rsp_status_in = 1'b1;
            end else begin
               head_in = pop_next;
               if (is_null(pop_next)) begin
                  tail_in = NULL_LINK;
               end
               count_in    = count_ff - 1'b1;
               rsp_node_in = is_null(head_ff) ? '0 : head_ff[NODE_W-1:0];
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               rsp_status_in = 1'b1;
            end else begin
               tail_in = pop_prev;
               if (is_null(pop_prev)) begin
                  head_in = NULL_LINK;
               end
               count_in    = count_ff - 1'b1;
               rsp_node_in = is_null(tail_ff) ? '0 : tail_ff[NODE_W-1:0];
            end
         end
         OP_UNLINK: begin
            if (empty) begin
               rsp_status_in = 1'b1;
            end else begin
               rsp_node_in = node_ff;
               if (head_ff == node_link) begin
                  head_in = rd_next_ff;
               end
               if (tail_ff == node_link) begin
                  tail_in = rd_prev_ff;
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NULL_LINK;
         tail_ff  <= NULL_LINK;
         count_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_node_ff   <= rsp_node_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_node_out   = rsp_node_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_list_count = rsp_count_ff;

endmodule

### rtl/doubly_linked_list_manager_core.sv
`timescale 1ns / 1ps
// Doubly linked list manager over a pool of node indices: top level.
// Depends on dllm_pkg, dllm_ctrl, dllm_dp.
//
// Usage:
//   Command side: drive req_op / req_node and raise start; the word is taken
//   at a clock edge with start high and busy low. Ops: insert front, insert
//   back, pop front, pop back, unlink node.
//   Response side: one response word per command on rsp_node_out, rsp_status
//   and rsp_list_count, valid for exactly one cycle while rsp_valid is high.
//   There is no backpressure; the receiver must capture it in that cycle.
//   Sequence: the accepting edge moves the sequencer to execute; the edge that
//   ends execute loads the response registers and raises rsp_valid.
//   A new command is taken only once the last one is done. The issue step
//   reads the neighbor link from the synchronous next/prev link memories,
//   the execute step writes the fixed-up links back; busy is high during
//   execute, and a new command may be taken while the response is shown.
//   Reset: head and tail go to null, count to zero; the link memories are
//   not cleared and need no sweep, so commands are taken right after reset.
module doubly_linked_list_manager_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dllm_pkg::OP_W-1:0]   req_op,
   input  logic [dllm_pkg::NODE_W-1:0] req_node,
   output logic                        rsp_valid,
   output logic [dllm_pkg::NODE_W-1:0] rsp_node_out,
   output logic                        rsp_status,
   output logic [dllm_pkg::CNT_W-1:0]  rsp_list_count
);
   import dllm_pkg::*;

   cmd_type cmd;

   dllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dllm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_node       (req_node),
      .rsp_node_out   (rsp_node_out),
      .rsp_status     (rsp_status),
      .rsp_list_count (rsp_list_count)
   );

   // a taken command always executes for exactly one cycle
   a_issue_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not enter execute");

   a_exec_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("execute did not finish with a response");

   a_rsp_only_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a preceding execute cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_count <= CNT_W'(NODES)))
      else $error("list count beyond pool size");

   a_empty_node_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_node_out == '0))
      else $error("empty removal reported a node");

endmodule

### tb/tb_doubly_linked_list_manager_core.sv
`timescale 1ns / 1ps
// Self-checking bench for doubly_linked_list_manager_core: directed and random list commands,
// predicted with a local linked list model. Depends on dllm_pkg and the core RTL.
module tb_doubly_linked_list_manager_core;
   import dllm_pkg::*;

   localparam int N_ITEMS = 1400;
   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] node;
   } list_cmd_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      logic              status;
      logic [CNT_W-1:0]  list_count;
   } list_resp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [NODE_W-1:0]   req_node = '0;
   logic                rsp_valid;
   logic [NODE_W-1:0]   rsp_node_out;
   logic                rsp_status;
   logic [CNT_W-1:0]    rsp_list_count;

   doubly_linked_list_manager_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_node       (req_node),
      .rsp_valid      (rsp_valid),
      .rsp_node_out   (rsp_node_out),
      .rsp_status     (rsp_status),
      .rsp_list_count (rsp_list_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   logic [LINK_W-1:0] succ_tbl [NODES];
   logic [LINK_W-1:0] pred_tbl [NODES];
   logic [LINK_W-1:0] front_ptr = NULL_LINK;
   logic [LINK_W-1:0] back_ptr  = NULL_LINK;
   logic [CNT_W-1:0]  list_len  = '0;

   list_cmd_type  cmd_backlog [$];
   list_resp_type resp_due [$];
   int total_cmds, n_issued, n_accepted, n_checked, n_errors;
   int n_empty_rm, n_full_ins, peak_len;

   // link accesses through null or out-of-pool indexes read null and write nothing
   function automatic logic [LINK_W-1:0] next_of(input logic [LINK_W-1:0] i);
      return (i < NODES) ? succ_tbl[i[NODE_W-1:0]] : NULL_LINK;
   endfunction

   function automatic logic [LINK_W-1:0] prev_of(input logic [LINK_W-1:0] i);
      return (i < NODES) ? pred_tbl[i[NODE_W-1:0]] : NULL_LINK;
   endfunction

   function automatic void set_next(input logic [LINK_W-1:0] i, input logic [LINK_W-1:0] v);
      if (i < NODES) succ_tbl[i[NODE_W-1:0]] = v;
   endfunction

   function automatic void set_prev(input logic [LINK_W-1:0] i, input logic [LINK_W-1:0] v);
      if (i < NODES) pred_tbl[i[NODE_W-1:0]] = v;
   endfunction

   function automatic void apply_list_op(input logic [OP_W-1:0] op,
                                         input logic [NODE_W-1:0] node);
      list_resp_type     r;
      logic [LINK_W-1:0] n, victim, nx, pv;
      n = LINK_W'(node);
      r = '0;
      case (op)
         OP_INS_FRONT: begin
            set_next(n, front_ptr);
            set_prev(n, NULL_LINK);
            if (list_len == 0) back_ptr = n;
            else set_prev(front_ptr, n);
            front_ptr = n;
            if (list_len < NODES) list_len++;
            else n_full_ins++;
            r.node_out = node;
         end
         OP_INS_BACK: begin
            set_prev(n, back_ptr);
            set_next(n, NULL_LINK);
            if (list_len == 0) front_ptr = n;
            else set_next(back_ptr, n);
            back_ptr = n;
            if (list_len < NODES) list_len++;
            else n_full_ins++;
            r.node_out = node;
         end
         OP_POP_FRONT: begin
            if (list_len == 0) begin
               r.status = 1'b1;
               n_empty_rm++;
            end else begin
               victim = front_ptr;
               front_ptr = next_of(victim);
               if (front_ptr >= NODES) back_ptr = NULL_LINK;
               else set_prev(front_ptr, NULL_LINK);
               list_len--;
               r.node_out = (victim < NODES) ? victim[NODE_W-1:0] : '0;
            end
         end
         OP_POP_BACK: begin
            if (list_len == 0) begin
               r.status = 1'b1;
               n_empty_rm++;
            end else begin
               victim = back_ptr;
               back_ptr = prev_of(victim);
               if (back_ptr >= NODES) front_ptr = NULL_LINK;
               else set_next(back_ptr, NULL_LINK);
               list_len--;
               r.node_out = (victim < NODES) ? victim[NODE_W-1:0] : '0;
            end
         end
         OP_UNLINK: begin
            if (list_len == 0) begin
               r.status = 1'b1;
               n_empty_rm++;
            end else begin
               nx = next_of(n);
               pv = prev_of(n);
               if (n == front_ptr) front_ptr = nx;
               if (n == back_ptr) back_ptr = pv;
               set_next(pv, nx);
               set_prev(nx, pv);
               list_len--;
               r.node_out = node;
            end
         end
         default: ;
      endcase
      r.list_count = list_len;
      if (list_len > peak_len) peak_len = list_len;
      resp_due.push_back(r);
   endfunction

   // ---------------------------------------------------------------- stimulus shadow
   // The count never depends on link contents, so gen_cnt is exact even after
   // precondition violations; gen_order is trusted only while gen_clean is set.
   int unsigned gen_cnt = 0;
   bit          gen_written [NODES];
   bit          gen_member [NODES];
   int          gen_order [$];
   bit          gen_clean = 1'b1;

   function automatic void add_cmd(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node);
      cmd_backlog.push_back(list_cmd_type'{op, node});
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (gen_member[node]) gen_clean = 1'b0;
            gen_written[node] = 1'b1;
            if (gen_clean) begin
               if (op == OP_INS_FRONT) gen_order.push_front(int'(node));
               else gen_order.push_back(int'(node));
               gen_member[node] = 1'b1;
            end
            if (gen_cnt < NODES) gen_cnt++;
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (gen_cnt != 0) begin
               gen_cnt--;
               if (gen_clean && op == OP_POP_FRONT) gen_member[gen_order.pop_front()] = 1'b0;
               else if (gen_clean) gen_member[gen_order.pop_back()] = 1'b0;
            end
         end
         OP_UNLINK: begin
            if (gen_cnt != 0) begin
               gen_cnt--;
               if (!gen_member[node]) begin
                  gen_clean = 1'b0;
               end else if (gen_clean) begin
                  for (int i = 0; i < gen_order.size(); i++)
                     if (gen_order[i] == int'(node)) begin
                        gen_order.delete(i);
                        break;
                     end
                  gen_member[node] = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // drain by count, then insert-back on an empty count plus pop-front nulls head and tail
   function automatic void restore_clean();
      while (gen_cnt != 0)
         add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, NODE_W'($urandom));
      add_cmd(OP_INS_BACK, NODE_W'($urandom));
      add_cmd(OP_POP_FRONT, NODE_W'($urandom));
      gen_order.delete();
      foreach (gen_member[i]) gen_member[i] = 1'b0;
      gen_clean = 1'b1;
   endfunction

   function automatic logic [NODE_W-1:0] pick_free_node();
      logic [NODE_W-1:0] n;
      do n = NODE_W'($urandom); while (gen_member[n]);
      return n;
   endfunction

   // unlink only touches nodes whose links were written at least once
   function automatic logic [NODE_W-1:0] pick_written_node();
      logic [NODE_W-1:0] n;
      do n = NODE_W'($urandom); while (!gen_written[n]);
      return n;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : cmd_driver
      list_cmd_type nxt;
      int           idle_pct;
      if (!reset) begin
         if (start && !busy) begin
            apply_list_op(req_op, req_node);
            n_accepted++;
         end
         if (!start || !busy) begin
            idle_pct = (n_issued < total_cmds / 3) ? 22 :
                       (n_issued < 2 * total_cmds / 3) ? 82 : 0;
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt = cmd_backlog.pop_front();
               n_issued++;
               start    <= 1'b1;
               req_op   <= nxt.op;
               req_node <= nxt.node;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : rsp_monitor
      list_resp_type want;
      if (!reset && rsp_valid) begin
         if (resp_due.size() == 0) begin
            n_errors++;
            $display("%0t: response word with none expected: node_out=%0d status=%0d count=%0d",
                     $time, rsp_node_out, rsp_status, rsp_list_count);
         end else begin
            want = resp_due.pop_front();
            n_checked++;
            if (rsp_node_out !== want.node_out || rsp_status !== want.status ||
                rsp_list_count !== want.list_count) begin
               n_errors++;
               $display("%0t: expected node_out=%0d status=%0d count=%0d, got %0d %0d %0d",
                        $time, want.node_out, want.status, want.list_count,
                        rsp_node_out, rsp_status, rsp_list_count);
            end
         end
      end
   end

   // a correct run ends well before this timeout
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_ctl
      int                len, w, kind, episode;
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] nd;

      foreach (succ_tbl[i]) begin
         succ_tbl[i] = '0;
         pred_tbl[i] = '0;
      end

      // directed: empty removals, spare opcodes, field extremes, unlink at middle/head/tail
      add_cmd(OP_POP_FRONT, 6'd63);
      add_cmd(OP_POP_BACK, 6'd0);
      add_cmd(OP_RSVD_5, 6'd63);
      add_cmd(OP_RSVD_6, 6'd42);
      add_cmd(OP_RSVD_7, 6'd21);
      add_cmd(OP_INS_FRONT, 6'd63);
      add_cmd(OP_INS_BACK, 6'd0);
      add_cmd(OP_INS_FRONT, 6'd21);
      add_cmd(OP_INS_BACK, 6'd42);
      add_cmd(OP_UNLINK, 6'd63);
      add_cmd(OP_UNLINK, 6'd21);
      add_cmd(OP_UNLINK, 6'd42);
      add_cmd(OP_POP_BACK, 6'd63);
      add_cmd(OP_UNLINK, 6'd0);
      add_cmd(OP_INS_BACK, 6'd5);
      add_cmd(OP_POP_FRONT, 6'd0);
      // re-insert at the back cuts the list short; later pops find a null head
      add_cmd(OP_INS_FRONT, 6'd1);
      add_cmd(OP_INS_FRONT, 6'd2);
      add_cmd(OP_INS_BACK, 6'd2);
      add_cmd(OP_POP_FRONT, 6'd0);
      add_cmd(OP_POP_FRONT, 6'd0);
      add_cmd(OP_POP_BACK, 6'd0);
      restore_clean();

      episode = 0;
      while (cmd_backlog.size() < N_ITEMS) begin
         if (episode == 0 || $urandom_range(0, 99) < 4) begin
            // fill the pool, then one insert past full to hit count saturation
            while (gen_order.size() < NODES)
               add_cmd($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_free_node());
            add_cmd($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, NODE_W'($urandom));
            restore_clean();
         end else begin
            len = $urandom_range(8, 40);
            repeat (len) begin
               w = $urandom_range(0, 99);
               if (!gen_clean) begin
                  op = OP_W'($urandom_range(int'(OP_INS_FRONT), int'(OP_UNLINK)));
                  nd = (op == OP_UNLINK) ? pick_written_node() : NODE_W'($urandom);
                  add_cmd(op, nd);
               end else if (w < 88) begin
                  w = $urandom_range(0, 99);
                  if ((gen_order.size() == 0 && w < 80) || (w < 48 && gen_order.size() < NODES))
                     add_cmd($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_free_node());
                  else if (w < 72 || gen_order.size() == 0)
                     add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                             NODE_W'($urandom));
                  else
                     add_cmd(OP_UNLINK,
                             NODE_W'(gen_order[$urandom_range(0, gen_order.size() - 1)]));
               end else begin
                  kind = $urandom_range(0, 3);
                  case (kind)
                     0: add_cmd(OP_W'($urandom_range(int'(OP_RSVD_5), int'(OP_RSVD_7))),
                                NODE_W'($urandom));
                     1: begin
                        nd = (gen_order.size() != 0) ?
                             NODE_W'(gen_order[$urandom_range(0, gen_order.size() - 1)]) :
                             NODE_W'($urandom);
                        add_cmd($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, nd);
                     end
                     2: add_cmd(OP_UNLINK, pick_written_node());
                     default: add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                                      NODE_W'($urandom));
                  endcase
               end
            end
            if (!gen_clean || $urandom_range(0, 3) == 0) restore_clean();
         end
         episode++;
      end
      total_cmds = cmd_backlog.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != total_cmds || resp_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Ran %0d commands in %0d episodes; %0d responses checked, peak count %0d,",
               total_cmds, episode, n_checked, peak_len);
      $display("%0d removals from an empty list, %0d inserts into a full count",
               n_empty_rm, n_full_ins);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
